[design/kprc_pkg.sv]
// shared types and constants for the key press refcount matrix unit
package kprc_pkg;

  localparam int NUM_KEYS = 40;
  localparam int IDX_W    = 6;
  localparam int KEY_W    = $clog2(NUM_KEYS);
  localparam int CNT_W    = 8;
  localparam int MATRIX_W = 40;

  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_ZERO = '0;
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [IDX_W:0]   KEY_LIMIT = (IDX_W + 1)'(NUM_KEYS);

  typedef struct packed {
    logic [IDX_W-1:0] key_index;
    logic             is_release;
    logic             is_clear;
  } kprc_in_t;

  typedef struct packed {
    logic                event_valid;
    logic                event_is_press;
    logic                event_is_clear;
    logic [MATRIX_W-1:0] key_matrix;
  } kprc_out_t;

endpackage

[design/key_press_refcount_matrix_unit.sv]
// top level: per-key press reference counts and the packed key matrix
//
// one transaction per command: the command is taken at the edge where
// start is high and busy is low, the count memory is read at that edge,
// and in the update state (busy high) the count is updated and written
// back while the result is registered; result_strobe is then high for
// exactly one cycle with the result. a new command is taken only once
// busy has dropped, so the block finishes one command before the next.
// every command gives exactly one result: a first press gives event_valid
// with the press flag, a final release gives event_valid without it, a
// clear-all on press gives event_valid with event_is_clear and an empty
// matrix, and anything else (clear with release set, key index out of
// range, release at zero, repeat press) gives a result with event_valid
// low and the current matrix. counts saturate at the top value. the result
// cannot be stalled. after reset, and after a clear-all, no memory sweep is
// needed: per-key valid bits mark which counts have been written since, and
// an unmarked count reads as zero.
module key_press_refcount_matrix_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  kprc_pkg::kprc_in_t  item,
  output logic              result_strobe,
  output kprc_pkg::kprc_out_t result
);

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t state;

  // count memory and its per-key written marks
  logic [kprc_pkg::CNT_W-1:0] cnt_mem [kprc_pkg::NUM_KEYS];
  logic [kprc_pkg::CNT_W-1:0] rd_data;
  logic [kprc_pkg::NUM_KEYS-1:0] cnt_vld;

  // captured command
  kprc_pkg::kprc_in_t req;
  logic               in_range;
  logic [kprc_pkg::MATRIX_W-1:0] matrix;

  logic accept;
  logic in_range_next;
  logic [kprc_pkg::KEY_W-1:0] rd_addr;
  logic [kprc_pkg::KEY_W-1:0] key_addr;

  // update path
  logic [kprc_pkg::CNT_W-1:0] cur_cnt;
  logic [kprc_pkg::CNT_W-1:0] cnt_next;
  logic                       cnt_write;
  logic                       evt_valid;
  logic                       evt_press;
  logic                       evt_clear;
  logic [kprc_pkg::IDX_W-1:0] bit_pos;
  logic [kprc_pkg::MATRIX_W-1:0] matrix_next;

  assign accept        = start && !busy;
  assign in_range_next = {1'b0, item.key_index} < kprc_pkg::KEY_LIMIT;
  assign rd_addr       = item.key_index[kprc_pkg::KEY_W-1:0];
  assign key_addr      = req.key_index[kprc_pkg::KEY_W-1:0];

  // matrix bit of key k: row k div 8, msb-first within the row
  assign bit_pos = {req.key_index[kprc_pkg::IDX_W-1:3], ~req.key_index[2:0]};

  always_comb begin
    cur_cnt     = cnt_vld[key_addr] ? rd_data : kprc_pkg::CNT_ZERO;
    cnt_next    = cur_cnt;
    cnt_write   = 1'b0;
    evt_valid   = 1'b0;
    evt_press   = 1'b0;
    evt_clear   = 1'b0;
    matrix_next = matrix;
    priority if (req.is_clear) begin
      if (!req.is_release) begin
        evt_valid   = 1'b1;
        evt_clear   = 1'b1;
        matrix_next = '0;
      end
    end else if (in_range) begin
      if (req.is_release) begin
        if (cur_cnt != kprc_pkg::CNT_ZERO) begin
          cnt_next  = cur_cnt - kprc_pkg::CNT_ONE;
          cnt_write = 1'b1;
          if (cur_cnt == kprc_pkg::CNT_ONE) begin
            // final release drops the key out of the matrix
            evt_valid            = 1'b1;
            matrix_next[bit_pos] = 1'b0;
          end
        end
      end else begin
        cnt_write = 1'b1;
        if (cur_cnt != kprc_pkg::CNT_MAX) begin
          cnt_next = cur_cnt + kprc_pkg::CNT_ONE;
        end
        if (cur_cnt == kprc_pkg::CNT_ZERO) begin
          // first press puts the key into the matrix
          evt_valid            = 1'b1;
          evt_press            = 1'b1;
          matrix_next[bit_pos] = 1'b1;
        end
      end
    end
  end

  // count memory: read on accept, write back in the update cycle
  always_ff @(posedge clk) begin
    if (accept && in_range_next) begin
      rd_data <= cnt_mem[rd_addr];
    end
    if (state == ST_UPDATE && cnt_write) begin
      cnt_mem[key_addr] <= cnt_next;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= item;
      in_range <= in_range_next;
    end
    if (state == ST_UPDATE) begin
      result.event_valid    <= evt_valid;
      result.event_is_press <= evt_press;
      result.event_is_clear <= evt_clear;
      result.key_matrix     <= matrix_next;
    end
  end

  // control, marks and matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      busy          <= 1'b0;
      result_strobe <= 1'b0;
      cnt_vld       <= '0;
      matrix        <= '0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_UPDATE;
            busy  <= 1'b1;
          end
        end
        ST_UPDATE: begin
          state         <= ST_IDLE;
          busy          <= 1'b0;
          result_strobe <= 1'b1;
          matrix        <= matrix_next;
          if (evt_clear) begin
            cnt_vld <= '0;
          end else if (cnt_write) begin
            cnt_vld[key_addr] <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // a result only follows an update cycle
  a_strobe_after_update: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result strobe without a preceding update cycle");

  // an accepted command always enters the update cycle
  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !result_strobe))
    else $error("accepted command did not start an update");

  // a clear-all event leaves an empty matrix
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.event_is_clear) |-> (result.key_matrix == '0))
    else $error("clear event with keys still in the matrix");

  // press and clear flags only come with an event, never both
  a_flags_consistent: assert property (@(posedge clk) disable iff (rst)
    result_strobe && (result.event_is_press || result.event_is_clear) |->
      (result.event_valid && !(result.event_is_press && result.event_is_clear)))
    else $error("inconsistent event flags");

  // the result matrix is what the block holds afterwards
  a_matrix_tracks: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (result.key_matrix == matrix))
    else $error("result matrix differs from held matrix");

endmodule
